FILE: design/rwds_pkg.sv
// Package with the shared types and constants of the reversed word dictionary search.
package rwds_pkg;

    // Widths of the request and response fields.
    localparam int OPC_W = 2;
    localparam int CHR_W = 8;
    localparam int IDX_W = 12;
    localparam int CNT_X = 16;

    // Request operation codes.
    typedef enum logic [OPC_W-1:0] {
        OP_APPEND = 2'd0,
        OP_CLOSE  = 2'd1,
        OP_QUERY  = 2'd2,
        OP_CLEAR  = 2'd3
    } t_opcode;

    // Controller states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_QLEN,
        S_PROBE,
        S_MLEN,
        S_CMP,
        S_DONE
    } t_state;

    // Outcome of one string comparison (query against a dictionary word).
    typedef enum logic [1:0] {
        CMP_LT,
        CMP_EQ,
        CMP_GT
    } t_cmp;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic take;
        logic ld_qlen;
        logic probe;
        logic ld_mlen;
        logic cmp_run;
        logic emit;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic bad_idx;
        logic empty_range;
        logic cmp_done;
        t_cmp cmp_res;
        logic out_busy;
    } t_stat;

endpackage

FILE: design/rwds_if.sv
// Handshake interfaces for the request and response channels.
interface rwds_req_if;
    import rwds_pkg::*;
    logic               valid;
    logic               ready;
    logic [OPC_W-1:0]   opcode;
    logic [CHR_W-1:0]   char_in;
    logic [IDX_W-1:0]   word_index;
    modport source (output valid, output opcode, output char_in, output word_index,
                    input ready);
    modport sink   (input valid, input opcode, input char_in, input word_index,
                    output ready);
endinterface

interface rwds_rsp_if;
    import rwds_pkg::*;
    logic               valid;
    logic               ready;
    logic [IDX_W-1:0]   query_index;
    logic               found;
    logic               status;
    modport source (output valid, output query_index, output found, output status,
                    input ready);
    modport sink   (input valid, input query_index, input found, input status,
                    output ready);
endinterface

FILE: design/rwds_ram.sv
// Generic RAM with one write port and two registered read ports.
module rwds_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    output logic [WIDTH-1:0]         o_rdata_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_b
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write and registered reads.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end
endmodule

FILE: design/rwds_ctrl.sv
// Controller state machine that sequences loads, queries and binary-search probes.
module rwds_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic              i_out_ready,
    input  rwds_pkg::t_opcode i_opcode,
    input  rwds_pkg::t_stat   i_stat,
    output logic              o_ready,
    output rwds_pkg::t_cmd    o_cmd
);
    import rwds_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   free;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands.
    always_comb begin
        free    = !i_stat.out_busy || i_out_ready;
        n_state = r_state;
        o_cmd   = '0;
        o_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_ready = free;
                if (i_valid && free) begin
                    o_cmd.take = 1'b1;
                    if (i_opcode == OP_QUERY && !i_stat.bad_idx) begin
                        n_state = S_QLEN;
                    end
                end
            end
            S_QLEN: begin
                o_cmd.ld_qlen = 1'b1;
                n_state       = S_PROBE;
            end
            S_PROBE: begin
                o_cmd.probe = 1'b1;
                n_state     = i_stat.empty_range ? S_DONE : S_MLEN;
            end
            S_MLEN: begin
                o_cmd.ld_mlen = 1'b1;
                n_state       = S_CMP;
            end
            S_CMP: begin
                o_cmd.cmp_run = 1'b1;
                if (i_stat.cmp_done) begin
                    n_state = (i_stat.cmp_res == CMP_EQ) ? S_DONE : S_PROBE;
                end
            end
            S_DONE: begin
                if (free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end
endmodule

FILE: design/rwds_dp.sv
// Datapath: word stores, dictionary counters, search bounds, comparator and result register.
module rwds_dp #(
    parameter int MAX_WORDS  = 4096,
    parameter int WORD_CHARS = 40
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  rwds_pkg::t_cmd               i_cmd,
    input  logic [rwds_pkg::OPC_W-1:0]   i_opcode,
    input  logic [rwds_pkg::CHR_W-1:0]   i_char,
    input  logic [rwds_pkg::IDX_W-1:0]   i_index,
    input  logic                         i_out_ready,
    output rwds_pkg::t_stat              o_stat,
    output logic                         o_out_valid,
    output logic [rwds_pkg::IDX_W-1:0]   o_query_index,
    output logic                         o_found,
    output logic                         o_status
);
    import rwds_pkg::*;

    localparam int WW    = $clog2(MAX_WORDS);
    localparam int CW    = $clog2(MAX_WORDS + 1);
    localparam int LW    = $clog2(WORD_CHARS);
    localparam int DEPTH = MAX_WORDS * WORD_CHARS;
    localparam int AW    = $clog2(DEPTH);

    // Dictionary state.
    logic [CW-1:0] r_count;
    logic [LW-1:0] r_blen;
    logic [AW-1:0] r_wbase;

    // Query and search state.
    logic [IDX_W-1:0] r_qidx;
    logic [LW-1:0]    r_qlen;
    logic [AW-1:0]    r_qbase;
    logic [CW-1:0]    r_lo;
    logic [CW-1:0]    r_hiex;
    logic [WW-1:0]    r_mid;
    logic [LW-1:0]    r_mlen;
    logic [AW-1:0]    r_mbase;
    logic [LW-1:0]    r_k;
    logic             r_pend;
    logic             r_found;

    // Result register.
    logic             r_ovalid;
    logic [IDX_W-1:0] r_oidx;
    logic             r_ofound;
    logic             r_ostatus;

    // Memory ports.
    logic             c_we;
    logic [AW-1:0]    c_waddr;
    logic [CHR_W-1:0] c_wdata;
    logic [AW-1:0]    c_raddr_a;
    logic [AW-1:0]    c_raddr_b;
    logic [CHR_W-1:0] c_rdata_a;
    logic [CHR_W-1:0] c_rdata_b;
    logic             l_we;
    logic [WW-1:0]    l_raddr;
    logic [LW-1:0]    l_rdata;
    logic [LW-1:0]    l_rdata_b;

    logic             full;
    logic             mismatch;
    logic [LW-1:0]    cmp_len;
    logic [CW:0]      mid_sum;
    logic [WW-1:0]    mid_c;
    t_opcode          op;

    assign op   = t_opcode'(i_opcode);
    assign full = (r_count == CW'(MAX_WORDS));

    rwds_ram #(.WIDTH(CHR_W), .DEPTH(DEPTH)) u_chars (
        .i_clk     (i_clk),
        .i_we      (c_we),
        .i_waddr   (c_waddr),
        .i_wdata   (c_wdata),
        .i_raddr_a (c_raddr_a),
        .o_rdata_a (c_rdata_a),
        .i_raddr_b (c_raddr_b),
        .o_rdata_b (c_rdata_b)
    );

    rwds_ram #(.WIDTH(LW), .DEPTH(MAX_WORDS)) u_lens (
        .i_clk     (i_clk),
        .i_we      (l_we),
        .i_waddr   (r_count[WW-1:0]),
        .i_wdata   (r_blen),
        .i_raddr_a (l_raddr),
        .o_rdata_a (l_rdata),
        .i_raddr_b (l_raddr),
        .o_rdata_b (l_rdata_b)
    );

    // Store writes, with A-Z folded to lower case.
    always_comb begin
        c_we    = i_cmd.take && op == OP_APPEND && !full && r_blen < LW'(WORD_CHARS - 1);
        c_waddr = r_wbase + AW'(r_blen);
        c_wdata = (i_char >= 8'h41 && i_char <= 8'h5A) ? i_char + 8'h20 : i_char;
        l_we    = i_cmd.take && op == OP_CLOSE && !full;
    end

    // Midpoint of the current range and length read address.
    always_comb begin
        mid_sum = {1'b0, r_lo} + {1'b0, r_hiex} - (CW + 1)'(1);
        mid_c   = mid_sum[WW:1];
        l_raddr = i_cmd.probe ? mid_c : WW'(i_index);
    end

    // Comparator: one character pair a cycle, each read issued in the cycle before its compare.
    always_comb begin
        cmp_len   = (r_qlen < r_mlen) ? r_qlen : r_mlen;
        c_raddr_a = r_qbase + AW'(r_qlen) - AW'(1) - AW'(r_k);
        c_raddr_b = r_mbase + AW'(r_k);
        mismatch  = r_pend && (c_rdata_a != c_rdata_b);
        o_stat.cmp_res = CMP_EQ;
        o_stat.cmp_done = 1'b0;
        if (mismatch) begin
            o_stat.cmp_done = 1'b1;
            o_stat.cmp_res  = (c_rdata_a < c_rdata_b) ? CMP_LT : CMP_GT;
        end else if (r_k == cmp_len) begin
            o_stat.cmp_done = 1'b1;
            if (r_qlen < r_mlen) begin
                o_stat.cmp_res = CMP_LT;
            end else if (r_qlen > r_mlen) begin
                o_stat.cmp_res = CMP_GT;
            end
        end
        o_stat.bad_idx     = CNT_X'(i_index) >= CNT_X'(r_count);
        o_stat.empty_range = r_lo >= r_hiex;
        o_stat.out_busy    = r_ovalid;
    end

    // Control registers of the dictionary and the result channel.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_blen   <= '0;
            r_wbase  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cmd.take) begin
                unique case (op)
                    OP_APPEND: if (c_we) r_blen <= r_blen + LW'(1);
                    OP_CLOSE: begin
                        r_blen <= '0;
                        if (!full) begin
                            r_count <= r_count + CW'(1);
                            r_wbase <= r_wbase + AW'(WORD_CHARS);
                        end
                    end
                    OP_CLEAR: begin
                        r_count <= '0;
                        r_blen  <= '0;
                        r_wbase <= '0;
                    end
                    OP_QUERY: ;
                    default: ;
                endcase
            end
            if (i_cmd.emit || (i_cmd.take && op == OP_QUERY && o_stat.bad_idx)) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // Search registers and result payload.
    always_ff @(posedge i_clk) begin
        if (i_cmd.take && op == OP_QUERY) begin
            r_qidx    <= i_index;
            r_oidx    <= i_index;
            r_ofound  <= 1'b0;
            r_ostatus <= 1'b1;
            r_lo      <= '0;
            r_hiex    <= r_count;
        end
        if (i_cmd.ld_qlen) begin
            r_qlen  <= l_rdata;
            r_qbase <= AW'(WW'(r_qidx) * WORD_CHARS);
        end
        if (i_cmd.probe) begin
            r_mid   <= mid_c;
            r_found <= 1'b0;
        end
        if (i_cmd.ld_mlen) begin
            r_mlen  <= l_rdata;
            r_mbase <= AW'(r_mid * WORD_CHARS);
            r_k     <= '0;
            r_pend  <= 1'b0;
        end
        if (i_cmd.cmp_run) begin
            if (o_stat.cmp_done) begin
                r_pend <= 1'b0;
                unique case (o_stat.cmp_res)
                    CMP_EQ: r_found <= 1'b1;
                    CMP_GT: r_lo    <= CW'(r_mid) + CW'(1);
                    CMP_LT: r_hiex  <= CW'(r_mid);
                    default: ;
                endcase
            end else begin
                r_k    <= r_k + LW'(1);
                r_pend <= 1'b1;
            end
        end
        if (i_cmd.emit) begin
            r_oidx    <= r_qidx;
            r_ofound  <= r_found;
            r_ostatus <= 1'b0;
        end
    end

    assign o_out_valid   = r_ovalid;
    assign o_query_index = r_oidx;
    assign o_found       = r_ofound;
    assign o_status      = r_ostatus;
endmodule

FILE: design/reversed_word_dictionary_search.sv
// Top level of the reversed word dictionary search.
// Requests arrive on i_req: opcode 0 appends char_in to the word being built,
// 1 closes that word, 2 queries word_index and 3 clears the dictionary.
// Only a query gives a response on o_rsp: the echoed index, found and status.
// Appends, closes and clears are completed as they are accepted.
// A query with an index at or beyond the word count answers straight from idle with
// status 1. Otherwise the word is reversed on the fly and binary-searched:
// after the query length is loaded, each probe takes the midpoint, loads the
// probed word's length and compares up to the shorter length, one character
// pair a cycle, from the single character memory with two read ports; a query
// makes up to log2(word count) + 1 probes.
// One request is worked on at a time; the next one is taken only when the
// output register is empty or its response is being taken in the same cycle.
// While the receiver stalls a waiting response holds the block.
// Reset empties the dictionary and the output register; the stores themselves
// need no clearing.
module reversed_word_dictionary_search #(
    parameter int MAX_WORDS  = 4096,
    parameter int WORD_CHARS = 40
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    rwds_req_if.sink   i_req,
    rwds_rsp_if.source o_rsp
);
    import rwds_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    rwds_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_req.valid),
        .i_out_ready (o_rsp.ready),
        .i_opcode    (t_opcode'(i_req.opcode)),
        .i_stat      (stat),
        .o_ready     (i_req.ready),
        .o_cmd       (cmd)
    );

    rwds_dp #(.MAX_WORDS(MAX_WORDS), .WORD_CHARS(WORD_CHARS)) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_opcode      (i_req.opcode),
        .i_char        (i_req.char_in),
        .i_index       (i_req.word_index),
        .i_out_ready   (o_rsp.ready),
        .o_stat        (stat),
        .o_out_valid   (o_rsp.valid),
        .o_query_index (o_rsp.query_index),
        .o_found       (o_rsp.found),
        .o_status      (o_rsp.status)
    );
endmodule

FILE: tb/sv/tb_reversed_word_dictionary_search.sv
// Testbench for the reversed word dictionary search, with its own prediction of every query.
`timescale 1ns / 100ps

module tb_reversed_word_dictionary_search;
    import rwds_pkg::*;

    localparam int MAX_WORDS  = 4096;
    localparam int WORD_CHARS = 40;
    localparam int LAST_CHARS = WORD_CHARS - 1;
    localparam int ITEM_GOAL  = 950;
    localparam int GEN_MAX    = 64;

    // One expected query response.
    typedef struct packed {
        logic [IDX_W-1:0] query_index;
        logic             found;
        logic             status;
    } t_answer;

    logic i_clk;
    logic i_rst_n;

    rwds_req_if req_if ();
    rwds_rsp_if rsp_if ();

    reversed_word_dictionary_search #(
        .MAX_WORDS  (MAX_WORDS),
        .WORD_CHARS (WORD_CHARS)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if.sink),
        .o_rsp   (rsp_if.source)
    );

    // Predicted dictionary contents.
    logic [7:0] dict_chars [0:MAX_WORDS*WORD_CHARS-1];
    int         dict_len   [0:MAX_WORDS-1];
    int         dict_count;
    int         build_len;

    t_answer answer_queue [$];
    int      mismatch_count;
    int      request_count;
    bit      idle_enable;

    // Scratch dictionary used to build sorted word lists.
    logic [7:0] gen_chars [0:GEN_MAX-1][0:47];
    int         gen_len   [0:GEN_MAX-1];

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Byte-wise compare of text with stored word w: -1, 0 or 1.
    function automatic int compare_word(logic [7:0] text [0:WORD_CHARS-1], int len, int w);
        int n;
        int sl;
        sl = dict_len[w];
        n = (len < sl) ? len : sl;
        for (int k = 0; k < n; k++) begin
            if (text[k] != dict_chars[w*WORD_CHARS+k])
                return (text[k] < dict_chars[w*WORD_CHARS+k]) ? -1 : 1;
        end
        if (len == sl)
            return 0;
        return (len < sl) ? -1 : 1;
    endfunction

    // Binary search of the stored words for the reversal of word idx.
    function automatic logic reversal_present(int idx);
        logic [7:0] rev [0:WORD_CHARS-1];
        int len;
        int lo;
        int hi;
        int mid;
        int c;
        len = dict_len[idx];
        for (int k = 0; k < WORD_CHARS; k++)
            rev[k] = 8'h00;
        for (int k = 0; k < len; k++)
            rev[k] = dict_chars[idx*WORD_CHARS + len - 1 - k];
        lo = 0;
        hi = dict_count - 1;
        while (lo <= hi) begin
            mid = lo + (hi - lo) / 2;
            c = compare_word(rev, len, mid);
            if (c == 0)
                return 1'b1;
            if (c > 0)
                lo = mid + 1;
            else
                hi = mid - 1;
        end
        return 1'b0;
    endfunction

    // Updates the predicted state for one accepted request.
    task automatic apply_request(t_opcode op, logic [7:0] ch, logic [IDX_W-1:0] idx);
        t_answer ans;
        case (op)
            OP_APPEND: begin
                if (dict_count < MAX_WORDS && build_len < LAST_CHARS) begin
                    if (ch >= 8'h41 && ch <= 8'h5A)
                        ch = ch + 8'h20;
                    dict_chars[dict_count*WORD_CHARS + build_len] = ch;
                    build_len++;
                end
            end
            OP_CLOSE: begin
                if (dict_count < MAX_WORDS) begin
                    dict_len[dict_count] = build_len;
                    dict_count++;
                end
                build_len = 0;
            end
            OP_CLEAR: begin
                dict_count = 0;
                build_len = 0;
            end
            default: begin
                ans.query_index = idx;
                if (int'(idx) >= dict_count) begin
                    ans.found  = 1'b0;
                    ans.status = 1'b1;
                end else begin
                    ans.found  = reversal_present(int'(idx));
                    ans.status = 1'b0;
                end
                answer_queue.push_back(ans);
            end
        endcase
    endtask

    // Sends one request and waits for it to be accepted.
    task automatic send_req(t_opcode op, logic [7:0] ch, logic [IDX_W-1:0] idx);
        @(negedge i_clk);
        while (idle_enable && $urandom_range(99) < 7) begin
            req_if.valid = 1'b0;
            @(negedge i_clk);
        end
        req_if.valid      = 1'b1;
        req_if.opcode     = op;
        req_if.char_in    = ch;
        req_if.word_index = idx;
        do @(posedge i_clk); while (!req_if.ready);
        apply_request(op, ch, idx);
        request_count++;
    endtask

    task automatic send_word(logic [7:0] w [0:47], int len);
        for (int k = 0; k < len; k++)
            send_req(OP_APPEND, w[k], '0);
        send_req(OP_CLOSE, '0, '0);
    endtask

    // Response checking against the oldest expectation.
    always @(posedge i_clk) begin
        t_answer exp_ans;
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            if (answer_queue.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("Unexpected response: index %0d found %0b status %0b",
                             rsp_if.query_index, rsp_if.found, rsp_if.status);
            end else begin
                exp_ans = answer_queue.pop_front();
                if (rsp_if.query_index !== exp_ans.query_index ||
                    rsp_if.found !== exp_ans.found || rsp_if.status !== exp_ans.status) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display({"Mismatch: expected index %0d found %0b status %0b, ",
                                  "got index %0d found %0b status %0b"},
                                 exp_ans.query_index, exp_ans.found, exp_ans.status,
                                 rsp_if.query_index, rsp_if.found, rsp_if.status);
                end
            end
        end
    end

    // Receiver stalls at random.
    always @(negedge i_clk) begin
        rsp_if.ready = idle_enable ? ($urandom_range(99) >= 7) : 1'b1;
    end

    // Short directed words: uppercase, zero byte, empty, long and partial words.
    task automatic test_directed_words();
        send_req(OP_CLOSE, '0, '0);
        send_req(OP_APPEND, 8'h41, '0);
        send_req(OP_APPEND, 8'h62, '0);
        send_req(OP_CLOSE, '0, '0);
        send_req(OP_APPEND, 8'h00, '0);
        send_req(OP_APPEND, 8'hFF, '0);
        send_req(OP_CLOSE, '0, '0);
        send_req(OP_APPEND, 8'h42, '0);
        send_req(OP_APPEND, 8'h61, '0);
        send_req(OP_CLOSE, '0, '0);
        send_req(OP_QUERY, '0, 12'd0);
        send_req(OP_QUERY, '0, 12'd1);
        send_req(OP_QUERY, '0, 12'd2);
        send_req(OP_QUERY, '0, 12'd4);
        send_req(OP_QUERY, '0, 12'hFFF);
        // A partial word is not searched, and its index is still out of range.
        send_req(OP_APPEND, 8'h7A, '0);
        send_req(OP_QUERY, '0, 12'd4);
        send_req(OP_CLEAR, '0, '0);
        send_req(OP_QUERY, '0, 12'd0);
        // A long word keeps only its first characters.
        for (int k = 0; k < 45; k++)
            send_req(OP_APPEND, 8'h61, '0);
        send_req(OP_CLOSE, '0, '0);
        send_req(OP_QUERY, '0, 12'd0);
        send_req(OP_CLEAR, '0, '0);
    endtask

    // Fills the dictionary, then checks that appends and closes are dropped.
    task automatic test_full_dictionary();
        for (int w = 0; w < MAX_WORDS - 1; w++)
            send_req(OP_CLOSE, '0, '0);
        send_req(OP_APPEND, 8'h62, '0);
        send_req(OP_APPEND, 8'h61, '0);
        send_req(OP_CLOSE, '0, '0);
        send_req(OP_QUERY, '0, 12'd0);
        send_req(OP_QUERY, '0, 12'd4095);
        send_req(OP_APPEND, 8'h61, '0);
        send_req(OP_CLOSE, '0, '0);
        send_req(OP_QUERY, '0, 12'd4095);
        send_req(OP_CLEAR, '0, '0);
    endtask

    // Lowercased byte, as the block stores it.
    function automatic logic [7:0] fold(logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5A) ? c + 8'h20 : c;
    endfunction

    // True when scratch word a sorts after scratch word b.
    function automatic bit gen_after(int a, int b);
        int la;
        int lb;
        int n;
        la = (gen_len[a] < LAST_CHARS) ? gen_len[a] : LAST_CHARS;
        lb = (gen_len[b] < LAST_CHARS) ? gen_len[b] : LAST_CHARS;
        n = (la < lb) ? la : lb;
        for (int k = 0; k < n; k++) begin
            if (fold(gen_chars[a][k]) != fold(gen_chars[b][k]))
                return fold(gen_chars[a][k]) > fold(gen_chars[b][k]);
        end
        return la > lb;
    endfunction

    function automatic logic [7:0] pick_char();
        if ($urandom_range(99) < 15)
            return 8'($urandom);
        case ($urandom_range(4))
            0: return 8'h61;
            1: return 8'h62;
            2: return 8'h41;
            3: return 8'h42;
            default: return 8'h63;
        endcase
    endfunction

    // Sorted dictionaries with many reversal pairs, then queries.
    task automatic test_sorted_search();
        logic [7:0] tmp [0:47];
        int n;
        int tl;
        int src;
        while (request_count < ITEM_GOAL) begin
            n = $urandom_range(3, 24);
            for (int w = 0; w < n; w++) begin
                if (w > 0 && $urandom_range(99) < 30) begin
                    src = $urandom_range(w - 1);
                    gen_len[w] = gen_len[src];
                    for (int k = 0; k < gen_len[src]; k++)
                        gen_chars[w][k] = gen_chars[src][gen_len[src] - 1 - k];
                end else begin
                    gen_len[w] = ($urandom_range(99) < 5) ? $urandom_range(40, 47)
                                                           : $urandom_range(0, 6);
                    for (int k = 0; k < gen_len[w]; k++)
                        gen_chars[w][k] = pick_char();
                end
            end
            // Insertion sort on the stored form of each word.
            for (int i = 1; i < n; i++) begin
                for (int j = i; j > 0 && gen_after(j - 1, j); j--) begin
                    tmp = gen_chars[j];
                    gen_chars[j] = gen_chars[j - 1];
                    gen_chars[j - 1] = tmp;
                    tl = gen_len[j];
                    gen_len[j] = gen_len[j - 1];
                    gen_len[j - 1] = tl;
                end
            end
            send_req(OP_CLEAR, '0, '0);
            for (int w = 0; w < n; w++)
                send_word(gen_chars[w], gen_len[w]);
            for (int q = 0; q < n + 4; q++) begin
                if ($urandom_range(99) < 80)
                    send_req(OP_QUERY, '0, IDX_W'($urandom_range(n - 1)));
                else
                    send_req(OP_QUERY, '0, IDX_W'($urandom));
            end
        end
    endtask

    // Random requests of every kind, unsorted dictionaries included.
    task automatic test_random_noise();
        int r;
        for (int i = 0; i < 200; i++) begin
            r = $urandom_range(99);
            if (r < 55)
                send_req(OP_APPEND, 8'($urandom), IDX_W'($urandom));
            else if (r < 72)
                send_req(OP_CLOSE, 8'($urandom), IDX_W'($urandom));
            else if (r < 97)
                send_req(OP_QUERY, 8'($urandom),
                         ($urandom_range(1) && dict_count > 0) ?
                         IDX_W'($urandom_range(dict_count - 1)) : IDX_W'($urandom));
            else
                send_req(OP_CLEAR, 8'($urandom), IDX_W'($urandom));
        end
    endtask

    initial begin
        #20_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    initial begin
        int guard;
        req_if.valid      = 1'b0;
        req_if.opcode     = OP_APPEND;
        req_if.char_in    = '0;
        req_if.word_index = '0;
        i_rst_n           = 1'b0;
        dict_count        = 0;
        build_len         = 0;
        mismatch_count    = 0;
        request_count     = 0;
        idle_enable       = 1'b1;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed_words();
        test_random_noise();
        test_sorted_search();
        // A long stretch with no idling on either side.
        idle_enable = 1'b0;
        test_full_dictionary();
        idle_enable = 1'b1;

        @(negedge i_clk);
        req_if.valid = 1'b0;
        guard = 0;
        while (answer_queue.size() != 0 && guard < 200_000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (700) @(posedge i_clk);
        if (mismatch_count == 0 && answer_queue.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
